// File: src/lkv_pkg.sv
// lkv_pkg: shared types and constants of the lru key-value cache
package lkv_pkg;

  localparam int unsigned KEY_W           = 32;
  localparam int unsigned VAL_W           = 32;
  localparam int unsigned CAP_W           = 5;
  localparam int unsigned SLOT_W          = 8;   // wide enough for up to 256 entries
  localparam int unsigned ENTRIES_DEFAULT = 16;

  localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;
  localparam logic [VAL_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;
  localparam logic [VAL_W-1:0] SET_VALUE  = 32'h0000_0000;

  typedef enum logic {
    FUNC_GET = 1'b0,
    FUNC_SET = 1'b1
  } func_e;

  // outcome of one search pass over the valid entries
  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] hit_slot;
    logic [SLOT_W-1:0] hit_rank;
    logic [VAL_W-1:0]  hit_val;
    logic [SLOT_W-1:0] lru_slot;
    logic [SLOT_W-1:0] lru_rank;
  } scan_res_t;

endpackage

// File: src/lkv_ram.sv
// lkv_ram: one-write one-read synchronous memory with registered read data
module lkv_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/lkv_scan.sv
// lkv_scan: accumulates key match and least recent entry over a search pass
module lkv_scan #(
  parameter int unsigned IDX_W = 4
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      clear_i,
  input  logic                      valid_i,
  input  logic [IDX_W-1:0]          idx_i,
  input  logic [lkv_pkg::KEY_W-1:0] key_i,
  input  logic [lkv_pkg::KEY_W-1:0] key_rd_i,
  input  logic [lkv_pkg::VAL_W-1:0] val_rd_i,
  input  logic [IDX_W-1:0]          rank_rd_i,
  output lkv_pkg::scan_res_t        res_o
);

  logic                      hit_q, hit_d;
  logic [IDX_W-1:0]          hit_slot_q, hit_slot_d;
  logic [IDX_W-1:0]          hit_rank_q, hit_rank_d;
  logic [lkv_pkg::VAL_W-1:0] hit_val_q, hit_val_d;
  logic [IDX_W-1:0]          lru_slot_q, lru_slot_d;
  logic [IDX_W-1:0]          lru_rank_q, lru_rank_d;

  always_comb begin
    hit_d      = hit_q;
    hit_slot_d = hit_slot_q;
    hit_rank_d = hit_rank_q;
    hit_val_d  = hit_val_q;
    lru_slot_d = lru_slot_q;
    lru_rank_d = lru_rank_q;
    if (clear_i) begin
      hit_d      = 1'b0;
      lru_slot_d = '0;
      lru_rank_d = '0;
    end else if (valid_i) begin
      // first match wins, keys are unique anyway
      if (!hit_q && key_rd_i == key_i) begin
        hit_d      = 1'b1;
        hit_slot_d = idx_i;
        hit_rank_d = rank_rd_i;
        hit_val_d  = val_rd_i;
      end
      // strictly larger rank replaces, so ties keep the lower slot
      if (rank_rd_i > lru_rank_q) begin
        lru_slot_d = idx_i;
        lru_rank_d = rank_rd_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q      <= 1'b0;
      lru_slot_q <= '0;
      lru_rank_q <= '0;
    end else begin
      hit_q      <= hit_d;
      lru_slot_q <= lru_slot_d;
      lru_rank_q <= lru_rank_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_slot_q <= hit_slot_d;
    hit_rank_q <= hit_rank_d;
    hit_val_q  <= hit_val_d;
  end

  always_comb begin
    res_o.hit      = hit_q;
    res_o.hit_slot = lkv_pkg::SLOT_W'(hit_slot_q);
    res_o.hit_rank = lkv_pkg::SLOT_W'(hit_rank_q);
    res_o.hit_val  = hit_val_q;
    res_o.lru_slot = lkv_pkg::SLOT_W'(lru_slot_q);
    res_o.lru_rank = lkv_pkg::SLOT_W'(lru_rank_q);
  end

endmodule

// File: src/lru_key_value_cache.sv
// lru_key_value_cache: fully associative key-value store with lru replacement
//
//   channel   dir  handshake                      payload
//   s_axis    in   s_axis_tvalid / s_axis_tready  tdata: key, value; tuser: func
//   m_axis    out  m_axis_tvalid / m_axis_tready  tdata: read_value; tuser: hit, evicted
//   cfg       in   cfg_valid_i / cfg_ready_o      cfg_data_i: cache_capacity
//
// an item runs two passes over the entry memories at one entry per cycle: a search
// pass over keys, values and ranks, then a read-modify-write pass over the rank memory
// that also covers a newly added entry and that a get miss skips; an empty cache
// skips the search pass and its drain state
// one item is in work at a time; a finished result waits in the output register
// while the next item is taken, and the block stalls only before loading it
// reset clears occupancy and sets capacity to 16; memories are not cleared
// cfg_ready_o is always high; write it only while the block is idle
module lru_key_value_cache #(
  parameter int unsigned ENTRIES = lkv_pkg::ENTRIES_DEFAULT
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // input items
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [63:0]               s_axis_tdata,   // [31:0] key, [63:32] value
  input  logic [0:0]                s_axis_tuser,   // [0] func
  // results
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [31:0]               m_axis_tdata,   // [31:0] read_value
  output logic [1:0]                m_axis_tuser,   // [0] hit, [1] evicted
  // capacity register
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [lkv_pkg::CAP_W-1:0] cfg_data_i
);

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned OCC_W = $clog2(ENTRIES + 1);
  localparam int unsigned CMP_W = (OCC_W > lkv_pkg::CAP_W) ? OCC_W : lkv_pkg::CAP_W;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_SCAN   = 7'b0000010,  // issue key/value/rank reads
    ST_SDRAIN = 7'b0000100,  // last search read returns
    ST_DECIDE = 7'b0001000,  // pick target slot, write key/value
    ST_PROM   = 7'b0010000,  // rank read-modify-write pass
    ST_PDRAIN = 7'b0100000,  // last rank write
    ST_FINISH = 7'b1000000   // hand result to output register
  } state_e;

  state_e                    state_q, state_d;
  logic [OCC_W-1:0]          occ_q, occ_d;
  logic [lkv_pkg::CAP_W-1:0] cap_q;
  logic [IDX_W-1:0]          idx_q, idx_d;
  logic [OCC_W-1:0]          bound_q, bound_d;
  logic                      iss_v_q;
  logic [IDX_W-1:0]          iss_idx_q;

  lkv_pkg::func_e            op_q;
  logic [lkv_pkg::KEY_W-1:0] key_q;
  logic [lkv_pkg::VAL_W-1:0] val_q;
  logic [IDX_W-1:0]          tgt_q, tgt_d;
  logic [IDX_W-1:0]          trank_q, trank_d;
  logic                      res_hit_q, res_hit_d;
  logic                      res_ev_q, res_ev_d;
  logic [lkv_pkg::VAL_W-1:0] res_val_q, res_val_d;

  logic                      m_valid_q, m_valid_d;
  logic [31:0]               m_data_q;
  logic [1:0]                m_user_q;

  logic                      in_xfer;
  logic                      last_issue;
  logic                      load_out;
  logic                      scan_valid;
  lkv_pkg::scan_res_t        scan_res;

  logic                      kv_we_key, kv_we_val;
  logic [IDX_W-1:0]          kv_waddr;
  logic [lkv_pkg::KEY_W-1:0] key_rd;
  logic [lkv_pkg::VAL_W-1:0] val_rd;
  logic                      rank_we;
  logic [IDX_W-1:0]          rank_wdata;
  logic [IDX_W-1:0]          rank_rd;

  logic [CMP_W-1:0]          cap_ext, cap_eff, occ_ext;
  logic                      room;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign last_issue    = (OCC_W'(idx_q) + OCC_W'(1)) == bound_q;
  assign load_out      = (state_q == ST_FINISH) && (!m_valid_q || m_axis_tready);
  assign scan_valid    = iss_v_q && (state_q == ST_SCAN || state_q == ST_SDRAIN);

  // effective capacity: at least one, at most the number of entries
  always_comb begin
    cap_ext = CMP_W'(cap_q);
    occ_ext = CMP_W'(occ_q);
    if (cap_ext == '0) begin
      cap_eff = CMP_W'(1);
    end else if (cap_ext > CMP_W'(ENTRIES)) begin
      cap_eff = CMP_W'(ENTRIES);
    end else begin
      cap_eff = cap_ext;
    end
    room = occ_ext < cap_eff;
  end

  // control sequencer
  always_comb begin
    state_d   = state_q;
    occ_d     = occ_q;
    idx_d     = idx_q;
    bound_d   = bound_q;
    tgt_d     = tgt_q;
    trank_d   = trank_q;
    res_hit_d = res_hit_q;
    res_ev_d  = res_ev_q;
    res_val_d = res_val_q;
    kv_we_key = 1'b0;
    kv_we_val = 1'b0;
    kv_waddr  = tgt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          idx_d   = '0;
          bound_d = occ_q;
          state_d = (occ_q == '0) ? ST_DECIDE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (last_issue) begin
          state_d = ST_SDRAIN;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      ST_SDRAIN: begin
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        idx_d     = '0;
        res_hit_d = scan_res.hit;
        res_ev_d  = 1'b0;
        bound_d   = occ_q;
        if (op_q == lkv_pkg::FUNC_GET) begin
          if (scan_res.hit) begin
            res_val_d = scan_res.hit_val;
            tgt_d     = scan_res.hit_slot[IDX_W-1:0];
            trank_d   = scan_res.hit_rank[IDX_W-1:0];
            state_d   = ST_PROM;
          end else begin
            res_val_d = lkv_pkg::MISS_VALUE;
            state_d   = ST_FINISH;
          end
        end else begin
          res_val_d = lkv_pkg::SET_VALUE;
          kv_we_val = 1'b1;
          state_d   = ST_PROM;
          if (scan_res.hit) begin
            tgt_d   = scan_res.hit_slot[IDX_W-1:0];
            trank_d = scan_res.hit_rank[IDX_W-1:0];
          end else if (room) begin
            // new entry enters as least recent, then gets promoted
            kv_we_key = 1'b1;
            tgt_d     = occ_q[IDX_W-1:0];
            trank_d   = occ_q[IDX_W-1:0];
            occ_d     = occ_q + OCC_W'(1);
            bound_d   = occ_q + OCC_W'(1);
          end else begin
            kv_we_key = 1'b1;
            tgt_d     = scan_res.lru_slot[IDX_W-1:0];
            trank_d   = scan_res.lru_rank[IDX_W-1:0];
            res_ev_d  = 1'b1;
          end
          kv_waddr = tgt_d;
        end
      end
      ST_PROM: begin
        if (last_issue) begin
          state_d = ST_PDRAIN;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      ST_PDRAIN: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // rank update: target goes to zero, younger-than-target entries age by one
  always_comb begin
    rank_we = iss_v_q && (state_q == ST_PROM || state_q == ST_PDRAIN);
    if (iss_idx_q == tgt_q) begin
      rank_wdata = '0;
    end else if (rank_rd < trank_q) begin
      rank_wdata = rank_rd + IDX_W'(1);
    end else begin
      rank_wdata = rank_rd;
    end
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end
    if (load_out) begin
      m_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      occ_q     <= '0;
      cap_q     <= lkv_pkg::CAP_RESET;
      idx_q     <= '0;
      bound_q   <= '0;
      iss_v_q   <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      occ_q     <= occ_d;
      idx_q     <= idx_d;
      bound_q   <= bound_d;
      iss_v_q   <= (state_q == ST_SCAN) || (state_q == ST_PROM);
      m_valid_q <= m_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    iss_idx_q <= idx_q;
    tgt_q     <= tgt_d;
    trank_q   <= trank_d;
    res_hit_q <= res_hit_d;
    res_ev_q  <= res_ev_d;
    res_val_q <= res_val_d;
    if (in_xfer) begin
      op_q  <= lkv_pkg::func_e'(s_axis_tuser[0]);
      key_q <= s_axis_tdata[31:0];
      val_q <= s_axis_tdata[63:32];
    end
    if (load_out) begin
      m_data_q <= res_val_q;
      m_user_q <= {res_ev_q, res_hit_q};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  // entry memories, all read at the pass index
  lkv_ram #(
    .WIDTH (lkv_pkg::KEY_W),
    .DEPTH (ENTRIES)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (kv_we_key),
    .waddr_i (kv_waddr),
    .wdata_i (key_q),
    .raddr_i (idx_q),
    .rdata_o (key_rd)
  );

  lkv_ram #(
    .WIDTH (lkv_pkg::VAL_W),
    .DEPTH (ENTRIES)
  ) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (kv_we_val),
    .waddr_i (kv_waddr),
    .wdata_i (val_q),
    .raddr_i (idx_q),
    .rdata_o (val_rd)
  );

  // rank pass reads entry i while writing back entry i-1
  lkv_ram #(
    .WIDTH (IDX_W),
    .DEPTH (ENTRIES)
  ) u_rank_ram (
    .clk_i   (clk_i),
    .we_i    (rank_we),
    .waddr_i (iss_idx_q),
    .wdata_i (rank_wdata),
    .raddr_i (idx_q),
    .rdata_o (rank_rd)
  );

  lkv_scan #(
    .IDX_W (IDX_W)
  ) u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clear_i   (in_xfer),
    .valid_i   (scan_valid),
    .idx_i     (iss_idx_q),
    .key_i     (key_q),
    .key_rd_i  (key_rd),
    .val_rd_i  (val_rd),
    .rank_rd_i (rank_rd),
    .res_o     (scan_res)
  );

`ifndef SYNTH
  // a result only appears after the sequencer finished an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_FINISH))
    else $error("result loaded outside finish");

  // an eviction only happens on a miss
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("eviction flagged on a hit");

  // occupancy moves only when a slot is picked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (occ_q != $past(occ_q)) |-> $past(state_q == ST_DECIDE))
    else $error("occupancy changed outside decide");

  // rank write-back never hits the entry being read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rank_we && state_q == ST_PROM) |-> (iss_idx_q != idx_q))
    else $error("rank read and write collide");
`endif

endmodule

// File: test/lru_key_value_cache_tb.sv
// lru_key_value_cache_tb: self-checking stream testbench for the lru key-value cache
`timescale 1ns / 100ps

module lru_key_value_cache_tb;

  localparam int ENTRIES     = lkv_pkg::ENTRIES_DEFAULT;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct {
    lkv_pkg::func_e             func;
    logic [lkv_pkg::KEY_W-1:0]  key;
    logic [lkv_pkg::VAL_W-1:0]  value;
  } cache_op_t;

  typedef struct {
    logic                       hit;
    logic [lkv_pkg::VAL_W-1:0]  read_value;
    logic                       evicted;
  } cache_res_t;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       s_axis_tvalid;
  logic                       s_axis_tready;
  logic [63:0]                s_axis_tdata;   // [31:0] key, [63:32] value
  logic [0:0]                 s_axis_tuser;   // [0] func
  logic                       m_axis_tvalid;
  logic                       m_axis_tready;
  logic [31:0]                m_axis_tdata;   // [31:0] read_value
  logic [1:0]                 m_axis_tuser;   // [0] hit, [1] evicted
  logic                       cfg_valid_i;
  logic                       cfg_ready_o;
  logic [lkv_pkg::CAP_W-1:0]  cfg_data_i;

  // ops waiting to go out, and results the cache owes us
  cache_op_t   pending_ops[$];
  cache_res_t  expected_results[$];

  // shadow copy of the cache contents
  logic [lkv_pkg::KEY_W-1:0]  key_mem[ENTRIES];
  logic [lkv_pkg::VAL_W-1:0]  val_mem[ENTRIES];
  int                         rank_mem[ENTRIES];
  int                         occ;
  logic [lkv_pkg::CAP_W-1:0]  cap_reg;

  int   err_cnt;
  int   cycle_cnt;
  bit   idle_en;
  bit   in_taken;
  int   in_gap;
  int   out_gap;
  logic [lkv_pkg::KEY_W-1:0] key_pool[$];

  lru_key_value_cache u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // one get or set against the shadow cache, returns what the block must answer
  function automatic cache_res_t cache_access(cache_op_t op);
    cache_res_t res;
    int         slot;
    int         eff_cap;
    int         old_rank;
    int         i;
    bit         found;
    res.hit        = 1'b0;
    res.read_value = lkv_pkg::SET_VALUE;
    res.evicted    = 1'b0;
    slot  = 0;
    found = 1'b0;
    for (i = 0; i < occ; i++)
      if (!found && key_mem[i] == op.key) begin
        found = 1'b1;
        slot  = i;
      end
    res.hit = found;
    if (op.func == lkv_pkg::FUNC_GET) begin
      if (!found) begin
        res.read_value = lkv_pkg::MISS_VALUE;
        return res;
      end
      res.read_value = val_mem[slot];
    end else if (found) begin
      val_mem[slot] = op.value;
    end else begin
      // zero capacity behaves as one, anything past the entry count saturates
      eff_cap = (cap_reg == 0) ? 1 : ((cap_reg > ENTRIES) ? ENTRIES : int'(cap_reg));
      if (occ < eff_cap) begin
        slot           = occ;
        rank_mem[slot] = occ;
        occ++;
      end else begin
        // first slot with the oldest rank is the victim
        slot = 0;
        for (i = 1; i < occ; i++)
          if (rank_mem[i] > rank_mem[slot]) slot = i;
        res.evicted = 1'b1;
      end
      key_mem[slot] = op.key;
      val_mem[slot] = op.value;
    end
    // promote: entries more recent than this one age by one
    old_rank = rank_mem[slot];
    for (i = 0; i < occ; i++)
      if (i != slot && rank_mem[i] < old_rank) rank_mem[i]++;
    rank_mem[slot] = 0;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch %s: got %h, want %h", $realtime, what, got, want);
    err_cnt++;
  endtask

  task automatic push_op(lkv_pkg::func_e func, logic [lkv_pkg::KEY_W-1:0] key,
                         logic [lkv_pkg::VAL_W-1:0] value);
    cache_op_t op;
    op.func  = func;
    op.key   = key;
    op.value = value;
    pending_ops.push_back(op);
  endtask

  // block until every op went out and every result came back
  task automatic drain();
    while (pending_ops.size() != 0 || expected_results.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [lkv_pkg::CAP_W-1:0] cap);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= cap;
    do @(posedge clk_i); while (!cfg_ready_o);
    cap_reg = cap;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // random traffic, mostly on a key set a bit larger than the capacity so that
  // hits, overwrites and evictions all show up
  task automatic push_random(int n_ops, int pool_n);
    logic [lkv_pkg::KEY_W-1:0] key;
    int                        pick;
    int                        i;
    key_pool.delete();
    for (i = 0; i < pool_n; i++) key_pool.push_back($urandom);
    for (i = 0; i < n_ops; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 75)
        key = key_pool[$urandom_range(0, pool_n - 1)];
      else if (pick < 88)
        key = $urandom;
      else begin
        case ($urandom_range(0, 3))
          0:       key = 32'h8000_0000;
          1:       key = 32'h7FFF_FFFF;
          2:       key = 32'h0000_0000;
          default: key = 32'hFFFF_FFFF;
        endcase
      end
      push_op(lkv_pkg::func_e'($urandom_range(0, 1)), key, $urandom);
    end
  endtask

  // input driver: holds an offered transfer until it is taken
  always @(negedge clk_i) begin : drive_items
    if (rst_ni && !(s_axis_tvalid && !in_taken)) begin
      in_taken = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_ops.size() != 0) begin
        if (idle_en && $urandom_range(0, 9) == 0) begin
          in_gap = $urandom_range(1, 17) - 1;
          s_axis_tvalid <= 1'b0;
        end else begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {pending_ops[0].value, pending_ops[0].key};
          s_axis_tuser  <= pending_ops[0].func;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result sink with random stall bursts
  always @(negedge clk_i) begin : drive_ready
    if (rst_ni) begin
      if (out_gap > 0) begin
        out_gap--;
        m_axis_tready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        out_gap = $urandom_range(1, 17) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // monitor: predict on each input transfer, check each output transfer
  always @(posedge clk_i) begin : monitor
    cache_res_t want;
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("RESULT: ERROR");
      $finish;
    end else if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(cache_access(pending_ops[0]));
        void'(pending_ops.pop_front());
        in_taken = 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", m_axis_tdata, 32'h0);
        end else begin
          want = expected_results.pop_front();
          if (m_axis_tuser[0] !== want.hit)
            report_mismatch("hit", 32'(m_axis_tuser[0]), 32'(want.hit));
          if (m_axis_tdata !== want.read_value)
            report_mismatch("read_value", m_axis_tdata, want.read_value);
          if (m_axis_tuser[1] !== want.evicted)
            report_mismatch("evicted", 32'(m_axis_tuser[1]), 32'(want.evicted));
        end
      end
    end
  end

  initial begin : stimulus
    logic [lkv_pkg::CAP_W-1:0] caps[10];
    int                        eff;
    int                        k;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    err_cnt       = 0;
    cycle_cnt     = 0;
    in_taken      = 1'b0;
    in_gap        = 0;
    out_gap       = 0;
    idle_en       = 1'b1;
    occ           = 0;
    cap_reg       = lkv_pkg::CAP_RESET;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty miss, extreme keys and values, overwrite, get with value set
    push_op(lkv_pkg::FUNC_GET, 32'h0000_0000, 32'hFFFF_FFFF);
    push_op(lkv_pkg::FUNC_SET, 32'h8000_0000, 32'h7FFF_FFFF);
    push_op(lkv_pkg::FUNC_SET, 32'h7FFF_FFFF, 32'h8000_0000);
    push_op(lkv_pkg::FUNC_SET, 32'h0000_0000, 32'h0000_0000);
    push_op(lkv_pkg::FUNC_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_op(lkv_pkg::FUNC_GET, 32'h8000_0000, 32'hA5A5_A5A5);
    push_op(lkv_pkg::FUNC_GET, 32'h7FFF_FFFF, 32'h0000_0000);
    push_op(lkv_pkg::FUNC_GET, 32'hFFFF_FFFF, 32'h0000_0000);  // stored -1 with hit set
    push_op(lkv_pkg::FUNC_SET, 32'h0000_0000, 32'h5555_5555);
    push_op(lkv_pkg::FUNC_GET, 32'h0000_0000, 32'h0000_0000);
    push_op(lkv_pkg::FUNC_GET, 32'h1234_5678, 32'h0000_0000);
    drain();

    // capacity zero acts as one, and sits below the current occupancy:
    // set misses replace the oldest entry and occupancy does not shrink
    write_capacity(5'd0);
    push_op(lkv_pkg::FUNC_SET, 32'hDEAD_BEEF, 32'hCAFE_F00D);
    push_op(lkv_pkg::FUNC_SET, 32'h0BAD_F00D, 32'h1111_1111);
    push_op(lkv_pkg::FUNC_GET, 32'hDEAD_BEEF, 32'h0000_0000);
    push_op(lkv_pkg::FUNC_GET, 32'h0BAD_F00D, 32'h0000_0000);
    push_op(lkv_pkg::FUNC_GET, 32'h0000_0000, 32'h0000_0000);
    push_op(lkv_pkg::FUNC_GET, 32'h8000_0000, 32'h0000_0000);
    push_op(lkv_pkg::FUNC_SET, 32'h7FFF_FFFF, 32'h2222_2222);
    push_op(lkv_pkg::FUNC_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    drain();

    // random phases across capacities, saturating values and extremes included
    caps = '{5'd31, 5'd1, 5'd2, 5'd5, 5'd20, 5'd3, 5'd16, 5'd8, 5'd0, 5'd16};
    for (k = 0; k < 10; k++) begin
      write_capacity(caps[k]);
      eff = (caps[k] == 0) ? 1 : ((caps[k] > ENTRIES) ? ENTRIES : int'(caps[k]));
      // last phase runs flat out; otherwise some phases also run without idling
      idle_en = (k < 9) && ($urandom_range(0, 3) != 0);
      if (!idle_en) begin
        in_gap  = 0;
        out_gap = 0;
      end
      push_random(120, eff + $urandom_range(1, 5));
      drain();
    end

    repeat (60) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/lkv_pkg.sv
src/lkv_ram.sv
src/lkv_scan.sv
src/lru_key_value_cache.sv
test/lru_key_value_cache_tb.sv
